@@ sv/rrf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrf_pkg
// Shared types and constants for the rounded rectangle pixel fill block.
// ----------------------------------------------------------------------------
package rrf_pkg;

  localparam int MAX_WIDTH    = 1024;
  localparam int MAX_HEIGHT   = 1024;
  localparam int RECT_H_MAX   = 196;
  localparam int RECT_W_NUM   = 442;
  localparam int PCT_MAX      = 50;

  // floor(m / 49) = (m * RECIP_49) >> RECIP_49_SH, exact for m < 43690
  localparam logic [14:0] RECIP_49    = 15'd21400;
  localparam int          RECIP_49_SH = 20;
  // floor(p / 25) = (p * RECIP_25) >> RECIP_25_SH, exact for p < 4681
  localparam logic [11:0] RECIP_25    = 12'd2622;
  localparam int          RECIP_25_SH = 16;

  // cycles from a register write until the derived geometry is valid
  localparam logic [2:0]  CFG_SETTLE  = 3'd5;

  localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [2:0] REG_RECT_HEIGHT  = 3'd2;
  localparam logic [2:0] REG_RADIUS_PCT   = 3'd3;
  localparam logic [2:0] REG_FILL_RED     = 3'd4;
  localparam logic [2:0] REG_FILL_GREEN   = 3'd5;
  localparam logic [2:0] REG_FILL_BLUE    = 3'd6;
  localparam logic [2:0] REG_TRANSPARENT  = 3'd7;

  typedef struct packed {
    logic [10:0] image_width;
    logic [10:0] image_height;
    logic [7:0]  rect_height;
    logic [5:0]  corner_pct;
  } cfg_geom_t;

  typedef struct packed {
    logic [9:0]  w_last;   // image width - 1
    logic [9:0]  h_last;   // image height - 1
    logic [9:0]  off_x;    // left edge of rectangle
    logic [9:0]  off_y;    // top edge of rectangle
    logic [9:0]  rect_w;
    logic [7:0]  rect_h;
    logic [6:0]  rad;
    logic [9:0]  x_hi;     // last column of the inner core, local
    logic [7:0]  y_hi;     // last row of the inner core, local
    logic [13:0] rad_sq;
  } geom_t;

endpackage

@@ sv/rrf_geom.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrf_geom
// Derives the clamped rectangle geometry from the configuration registers
// through a short register pipeline.
// ----------------------------------------------------------------------------
module rrf_geom
  import rrf_pkg::*;
(
  input  logic      clk,
  input  cfg_geom_t cfg,
  output geom_t     geom
);

  // stage 1
  logic [10:0] w1_r, w1_nxt, h1_r, h1_nxt;
  logic [7:0]  req1_nxt, rh1_r, rh1_nxt;
  logic [5:0]  pct1_r, pct1_nxt;
  logic [16:0] wnum1;
  logic [14:0] m1_r, m1_nxt;
  // stage 2
  logic [10:0] w2_r, h2_r;
  logic [7:0]  rh2_r;
  logic [29:0] wprod2;
  logic [9:0]  rwraw2_r, rwraw2_nxt;
  logic [13:0] radp2_r, radp2_nxt;
  // stage 3
  logic [10:0] w3_r, h3_r;
  logic [7:0]  rh3_r;
  logic [9:0]  rw3_r, rw3_nxt;
  logic [23:0] rprod3;
  logic [6:0]  radraw3_r, radraw3_nxt;
  // stage 4
  logic [10:0] w4_r, h4_r;
  logic [7:0]  rh4_r;
  logic [9:0]  rw4_r;
  logic [9:0]  mn4;
  logic [6:0]  radmax4;
  logic [6:0]  rad4_r, rad4_nxt;
  logic [10:0] dw4, dh4;
  logic [9:0]  offx4_r, offx4_nxt, offy4_r, offy4_nxt;
  // stage 5
  geom_t       geom_r, geom_nxt;
  logic [9:0]  wl5, hl5;

  always_comb begin
    if (cfg.image_width == 11'd0) begin
      w1_nxt = 11'd1;
    end else if (cfg.image_width > 11'(MAX_WIDTH)) begin
      w1_nxt = 11'(MAX_WIDTH);
    end else begin
      w1_nxt = cfg.image_width;
    end
    if (cfg.image_height == 11'd0) begin
      h1_nxt = 11'd1;
    end else if (cfg.image_height > 11'(MAX_HEIGHT)) begin
      h1_nxt = 11'(MAX_HEIGHT);
    end else begin
      h1_nxt = cfg.image_height;
    end
    if (cfg.rect_height == 8'd0) begin
      req1_nxt = 8'd1;
    end else if (cfg.rect_height > 8'(RECT_H_MAX)) begin
      req1_nxt = 8'(RECT_H_MAX);
    end else begin
      req1_nxt = cfg.rect_height;
    end
    pct1_nxt = (cfg.corner_pct > 6'(PCT_MAX)) ? 6'(PCT_MAX) : cfg.corner_pct;
    rh1_nxt  = ({3'd0, req1_nxt} > h1_nxt) ? h1_nxt[7:0] : req1_nxt;
    // round(req * 442 / 196), the /196 split as /4 then /49
    wnum1    = {9'd0, req1_nxt} * 17'(RECT_W_NUM) + 17'(RECT_H_MAX / 2);
    m1_nxt   = wnum1[16:2];
  end

  always_comb begin
    wprod2     = {15'd0, m1_r} * {15'd0, RECIP_49};
    rwraw2_nxt = wprod2[RECIP_49_SH +: 10];
    radp2_nxt  = {6'd0, rh1_r} * {8'd0, pct1_r};
  end

  always_comb begin
    rw3_nxt     = ({1'b0, rwraw2_r} > w2_r) ? w2_r[9:0] : rwraw2_r;
    // /100 split as /4 then /25
    rprod3      = {12'd0, radp2_r[13:2]} * {12'd0, RECIP_25};
    radraw3_nxt = rprod3[RECIP_25_SH +: 7];
  end

  always_comb begin
    mn4       = ({2'd0, rh3_r} < rw3_r) ? {2'd0, rh3_r} : rw3_r;
    radmax4   = mn4[7:1];
    rad4_nxt  = (radraw3_r > radmax4) ? radmax4 : radraw3_r;
    dw4       = w3_r - {1'b0, rw3_r};
    dh4       = h3_r - {3'd0, rh3_r};
    offx4_nxt = dw4[10:1];
    offy4_nxt = dh4[10:1];
  end

  always_comb begin
    wl5             = 10'(w4_r - 11'd1);
    hl5             = 10'(h4_r - 11'd1);
    geom_nxt.w_last = wl5;
    geom_nxt.h_last = hl5;
    geom_nxt.off_x  = offx4_r;
    geom_nxt.off_y  = offy4_r;
    geom_nxt.rect_w = rw4_r;
    geom_nxt.rect_h = rh4_r;
    geom_nxt.rad    = rad4_r;
    geom_nxt.x_hi   = rw4_r - {3'd0, rad4_r} - 10'd1;
    geom_nxt.y_hi   = rh4_r - {1'b0, rad4_r} - 8'd1;
    geom_nxt.rad_sq = {7'd0, rad4_r} * {7'd0, rad4_r};
  end

  always_ff @(posedge clk) begin
    w1_r      <= w1_nxt;
    h1_r      <= h1_nxt;
    rh1_r     <= rh1_nxt;
    pct1_r    <= pct1_nxt;
    m1_r      <= m1_nxt;
    w2_r      <= w1_r;
    h2_r      <= h1_r;
    rh2_r     <= rh1_r;
    rwraw2_r  <= rwraw2_nxt;
    radp2_r   <= radp2_nxt;
    w3_r      <= w2_r;
    h3_r      <= h2_r;
    rh3_r     <= rh2_r;
    rw3_r     <= rw3_nxt;
    radraw3_r <= radraw3_nxt;
    w4_r      <= w3_r;
    h4_r      <= h3_r;
    rh4_r     <= rh3_r;
    rw4_r     <= rw3_r;
    rad4_r    <= rad4_nxt;
    offx4_r   <= offx4_nxt;
    offy4_r   <= offy4_nxt;
    geom_r    <= geom_nxt;
  end

  assign geom = geom_r;

endmodule

@@ sv/rounded_rect_pixel_fill_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rounded_rect_pixel_fill_top
// Fills a centered rounded rectangle over a raster-order RGBA pixel stream.
//
// in_*  : source pixels in row-major order, one word per pixel
// out_* : result pixels, out_tlast marks the final pixel of the image
// cfg_* : register writes, taken in the cycle cfg_wr_en is high
//
// Throughput is one pixel per clock while the receiver keeps up and no write
// is settling; pixels pass the input, corner-distance and result registers.
// When the receiver stalls, words stay in the three stages and in_tready
// drops once they are full. Rectangle geometry comes from a five-stage
// register chain fed by the registers, so after reset or any register write
// in_tready stays low until the settle counter is zero. Reset restores the
// register defaults and clears the column and row counters; writes do not.
// ----------------------------------------------------------------------------
module rounded_rect_pixel_fill_top
  import rrf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // pixel_in
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // pixel_out
  output logic        out_tlast,  // frame_last
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [10:0] cfg_data
);

  cfg_geom_t   cfg_r;
  logic [7:0]  red_r, green_r, blue_r;
  logic        transp_r;
  logic [2:0]  settle_r;
  geom_t       geom;

  logic [9:0]  col_r, row_r;
  logic        row_end, frame_end, in_acc;

  logic        v0_r, v1_r, v2_r;
  logic        adv0, adv1, adv2;
  logic [31:0] pix0_r, pix1_r, pix2_r;
  logic [9:0]  x0_r, y0_r;
  logic        last0_r, last1_r, last2_r;

  logic [11:0] lx, ly;
  logic        in_box_nxt, in_box_r;
  logic [11:0] dx_full, dy_full;
  logic [6:0]  dx_r, dy_r;
  logic [14:0] dist_sq;
  logic [31:0] pix2_nxt;

  rrf_geom u_geom (
    .clk  (clk),
    .cfg  (cfg_r),
    .geom (geom)
  );

  // registers and settle counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.image_width    <= 11'd442;
      cfg_r.image_height   <= 11'd196;
      cfg_r.rect_height    <= 8'd196;
      cfg_r.corner_pct     <= 6'd12;
      red_r                <= 8'd0;
      green_r              <= 8'd0;
      blue_r               <= 8'd0;
      transp_r             <= 1'b0;
      settle_r             <= CFG_SETTLE;
    end else begin
      if (cfg_wr_en) begin
        settle_r <= CFG_SETTLE;
        case (cfg_index)
          REG_IMAGE_WIDTH:  cfg_r.image_width    <= cfg_data;
          REG_IMAGE_HEIGHT: cfg_r.image_height   <= cfg_data;
          REG_RECT_HEIGHT:  cfg_r.rect_height    <= cfg_data[7:0];
          REG_RADIUS_PCT:   cfg_r.corner_pct     <= cfg_data[5:0];
          REG_FILL_RED:     red_r                <= cfg_data[7:0];
          REG_FILL_GREEN:   green_r              <= cfg_data[7:0];
          REG_FILL_BLUE:    blue_r               <= cfg_data[7:0];
          REG_TRANSPARENT:  transp_r             <= cfg_data[0];
          default: ;
        endcase
      end else if (settle_r != 3'd0) begin
        settle_r <= settle_r - 3'd1;
      end
    end
  end

  // stall control
  assign adv2      = !v2_r || out_tready;
  assign adv1      = !v1_r || adv2;
  assign adv0      = !v0_r || adv1;
  assign in_tready = adv0 && (settle_r == 3'd0);
  assign in_acc    = in_tvalid && in_tready;

  // raster position
  assign row_end   = col_r >= geom.w_last;
  assign frame_end = row_end && (row_r >= geom.h_last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= 10'd0;
      row_r <= 10'd0;
    end else if (in_acc) begin
      if (row_end) begin
        col_r <= 10'd0;
        row_r <= frame_end ? 10'd0 : row_r + 10'd1;
      end else begin
        col_r <= col_r + 10'd1;
      end
    end
  end

  // local position and corner offsets
  always_comb begin
    lx         = {2'd0, x0_r} - {2'd0, geom.off_x};
    ly         = {2'd0, y0_r} - {2'd0, geom.off_y};
    in_box_nxt = !lx[11] && (lx < {2'd0, geom.rect_w})
              && !ly[11] && (ly < {4'd0, geom.rect_h});
    if (lx < {5'd0, geom.rad}) begin
      dx_full = {5'd0, geom.rad} - lx;
    end else if (lx > {2'd0, geom.x_hi}) begin
      dx_full = lx - {2'd0, geom.x_hi};
    end else begin
      dx_full = 12'd0;
    end
    if (ly < {5'd0, geom.rad}) begin
      dy_full = {5'd0, geom.rad} - ly;
    end else if (ly > {4'd0, geom.y_hi}) begin
      dy_full = ly - {4'd0, geom.y_hi};
    end else begin
      dy_full = 12'd0;
    end
  end

  // corner test and fill
  always_comb begin
    dist_sq = {1'b0, {7'd0, dx_r} * {7'd0, dx_r}} + {1'b0, {7'd0, dy_r} * {7'd0, dy_r}};
    if (in_box_r && (dist_sq <= {1'b0, geom.rad_sq})) begin
      pix2_nxt = transp_r ? 32'd0 : {8'hFF, blue_r, green_r, red_r};
    end else begin
      pix2_nxt = pix1_r;
    end
  end

  // pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (adv0) begin
        v0_r <= in_acc;
      end
      if (adv1) begin
        v1_r <= v0_r;
      end
      if (adv2) begin
        v2_r <= v1_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      pix0_r  <= in_tdata;
      x0_r    <= col_r;
      y0_r    <= row_r;
      last0_r <= frame_end;
    end
    if (adv1) begin
      pix1_r   <= pix0_r;
      last1_r  <= last0_r;
      in_box_r <= in_box_nxt;
      dx_r     <= dx_full[6:0];
      dy_r     <= dy_full[6:0];
    end
    if (adv2) begin
      pix2_r  <= pix2_nxt;
      last2_r <= last1_r;
    end
  end

  assign out_tvalid = v2_r;
  assign out_tdata  = pix2_r;
  assign out_tlast  = last2_r;

endmodule
